@@ src/rthc_pkg.sv @@
// Shared types and constants for the RGB to HSL converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package rthc_pkg;

  // Fixed output field widths
  localparam int HUE_W = 16;
  localparam int SAT_W = 13;

  // Quotient bits per divide; one divider cell per bit
  localparam int QUO_BITS = 13;

  // Saturation is Q1.12
  localparam int SAT_FRAC = 12;

  // 3840 = 2^12 - 2^8 (1/64-degree units per 60-degree sextant)
  localparam int HUE_SH_HI = 12;
  localparam int HUE_SH_LO = 8;

  typedef logic signed [HUE_W-1:0] hue_t;
  typedef logic [QUO_BITS-1:0]     quo_t;

  // Hue offsets per max component, with the -3840 bias of the divider folded in
  localparam hue_t HUE_BASE_RED   = -16'sd3840;
  localparam hue_t HUE_BASE_GREEN = 16'sd3840;
  localparam hue_t HUE_BASE_BLUE  = 16'sd11520;

endpackage

`default_nettype wire

@@ src/rthc_prep.sv @@
// Front end of the converter: max/min, lightness, divider operands and hue offset.
// Two registered stages with valid/ready; depends on rthc_pkg.
`default_nettype none

module rthc_prep
  import rthc_pkg::*;
#(
  parameter int CB    = 8,
  parameter int NUM_W = 21
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [CB-1:0]    in_red,
  input  wire logic [CB-1:0]    in_green,
  input  wire logic [CB-1:0]    in_blue,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [NUM_W-1:0]      out_hue_rem,
  output logic [NUM_W-1:0]      out_hue_dsh,
  output logic [NUM_W-1:0]      out_sat_rem,
  output logic [NUM_W-1:0]      out_sat_dsh,
  output hue_t                  out_hue_base,
  output logic [CB:0]           out_light
);

  // ---- stage 1: max, min, hue branch ----
  logic [CB-1:0] mx_c, mn_c, x_c, y_c;
  hue_t          base_c;

  logic          s1_valid_r, s1_valid_nxt;
  logic [CB-1:0] s1_mx_r, s1_mn_r, s1_x_r, s1_y_r;
  hue_t          s1_base_r;
  logic          s1_ready;

  always_comb begin
    mx_c = in_red;
    mn_c = in_red;
    if (in_green > mx_c) mx_c = in_green;
    if (in_blue > mx_c) mx_c = in_blue;
    if (in_green < mn_c) mn_c = in_green;
    if (in_blue < mn_c) mn_c = in_blue;
    // numerator is x - y, offset per branch
    if (mx_c == in_red && mx_c != in_green) begin
      x_c    = in_green;
      y_c    = in_blue;
      base_c = HUE_BASE_RED;
    end else if (mx_c == in_green && mx_c != in_blue) begin
      x_c    = in_blue;
      y_c    = in_red;
      base_c = HUE_BASE_GREEN;
    end else begin
      x_c    = in_red;
      y_c    = in_green;
      base_c = HUE_BASE_BLUE;
    end
  end

  logic s2_valid_r, s2_valid_nxt;

  assign s1_ready     = !s2_valid_r || out_ready;
  assign in_ready     = !s1_valid_r || s1_ready;
  assign s1_valid_nxt = in_ready ? in_valid : s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mx_r   <= mx_c;
      s1_mn_r   <= mn_c;
      s1_x_r    <= x_c;
      s1_y_r    <= y_c;
      s1_base_r <= base_c;
    end
  end

  // ---- stage 2: delta, sum, saturation divisor, divider operands ----
  logic [CB-1:0]    delta_c;
  logic [CB:0]      sum_c, den_c, fd_c;
  logic [NUM_W-1:0] fd_w, hue_num_c, hue_dsh_c, sat_num_c, sat_dsh_c;
  hue_t             base2_c;

  localparam logic [CB:0] FULL    = {1'b0, {CB{1'b1}}};
  localparam logic [CB:0] TWOFULL = {{CB{1'b1}}, 1'b0};

  always_comb begin
    delta_c = s1_mx_r - s1_mn_r;
    sum_c   = {1'b0, s1_mx_r} + {1'b0, s1_mn_r};
    den_c   = (sum_c <= FULL) ? sum_c : (TWOFULL - sum_c);
    // x - y + delta lies in [0, 2*delta]
    fd_c    = {1'b0, s1_x_r} + {1'b0, delta_c} - {1'b0, s1_y_r};
    fd_w    = NUM_W'(fd_c);
    if (delta_c == '0) begin
      // grey: hue 0, saturation 0
      hue_num_c = '0;
      hue_dsh_c = NUM_W'(1) << (QUO_BITS - 1);
      sat_num_c = '0;
      sat_dsh_c = NUM_W'(1) << (QUO_BITS - 1);
      base2_c   = '0;
    end else begin
      hue_num_c = (fd_w << HUE_SH_HI) - (fd_w << HUE_SH_LO);
      hue_dsh_c = NUM_W'(delta_c) << (QUO_BITS - 1);
      sat_num_c = NUM_W'(delta_c) << SAT_FRAC;
      sat_dsh_c = NUM_W'(den_c) << (QUO_BITS - 1);
      base2_c   = s1_base_r;
    end
  end

  assign s2_valid_nxt = s1_ready ? s1_valid_r : s2_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_ready) begin
      out_hue_rem  <= hue_num_c;
      out_hue_dsh  <= hue_dsh_c;
      out_sat_rem  <= sat_num_c;
      out_sat_dsh  <= sat_dsh_c;
      out_hue_base <= base2_c;
      out_light    <= sum_c;
    end
  end

  assign out_valid = s2_valid_r;

endmodule

`default_nettype wire

@@ src/rthc_cell.sv @@
// One restoring-divide step for the hue and saturation quotients, one bit per cell.
// Registered stage with valid/ready; depends on rthc_pkg.
`default_nettype none

module rthc_cell
  import rthc_pkg::*;
#(
  parameter int NUM_W   = 21,
  parameter int LIGHT_W = 9
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [NUM_W-1:0]   in_hue_rem,
  input  wire logic [NUM_W-1:0]   in_hue_dsh,
  input  wire quo_t               in_hue_quo,
  input  wire logic [NUM_W-1:0]   in_sat_rem,
  input  wire logic [NUM_W-1:0]   in_sat_dsh,
  input  wire quo_t               in_sat_quo,
  input  wire hue_t               in_hue_base,
  input  wire logic [LIGHT_W-1:0] in_light,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [NUM_W-1:0]        out_hue_rem,
  output logic [NUM_W-1:0]        out_hue_dsh,
  output quo_t                    out_hue_quo,
  output logic [NUM_W-1:0]        out_sat_rem,
  output logic [NUM_W-1:0]        out_sat_dsh,
  output quo_t                    out_sat_quo,
  output hue_t                    out_hue_base,
  output logic [LIGHT_W-1:0]      out_light
);

  logic valid_r, valid_nxt;
  logic hue_ge, sat_ge;

  // compare against the shifted divisor, subtract when it fits
  assign hue_ge = (in_hue_rem >= in_hue_dsh);
  assign sat_ge = (in_sat_rem >= in_sat_dsh);

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_hue_rem  <= hue_ge ? (in_hue_rem - in_hue_dsh) : in_hue_rem;
      out_hue_dsh  <= in_hue_dsh >> 1;
      out_hue_quo  <= {in_hue_quo[QUO_BITS-2:0], hue_ge};
      out_sat_rem  <= sat_ge ? (in_sat_rem - in_sat_dsh) : in_sat_rem;
      out_sat_dsh  <= in_sat_dsh >> 1;
      out_sat_quo  <= {in_sat_quo[QUO_BITS-2:0], sat_ge};
      out_hue_base <= in_hue_base;
      out_light    <= in_light;
    end
  end

  assign out_valid = valid_r;

endmodule

`default_nettype wire

@@ src/rgb_to_hsl_converter_core.sv @@
// RGB to HSL converter, top level: front end, divider cell chain, output register.
// Depends on rthc_pkg, rthc_prep and rthc_cell.
//
// Usage:
//   Input channel in_valid/in_ready carries one pixel per beat (in_red, in_green,
//   in_blue, COMPONENT_BITS each). Output channel out_valid/out_ready carries one
//   beat per pixel: out_hue (signed 1/64 degree, -3840..19199, not wrapped),
//   out_saturation (Q1.12, 4096 = one) and out_lightness (max + min).
//   An input beat passes through 2 front-end stages, 13 divider cells (one
//   quotient bit each, hue and saturation in parallel) and the output register.
//   Throughput is one pixel per cycle while the receiver keeps out_ready high.
//   Every stage has its own valid bit and takes a new beat whenever it is empty
//   or its successor moves, so while the receiver stalls the chain keeps filling
//   its bubbles and in_ready stays high until all 16 stages hold a pixel.
//   Results come out in input order. Reset clears all valid bits; no pixel is
//   in flight afterwards and nothing else needs clearing.
`default_nettype none

module rgb_to_hsl_converter_core
  import rthc_pkg::*;
#(
  parameter int COMPONENT_BITS = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [COMPONENT_BITS-1:0] in_red,
  input  wire logic [COMPONENT_BITS-1:0] in_green,
  input  wire logic [COMPONENT_BITS-1:0] in_blue,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [HUE_W-1:0]        out_hue,
  output logic [SAT_W-1:0]               out_saturation,
  output logic [COMPONENT_BITS:0]        out_lightness
);

  localparam int NUM_W   = COMPONENT_BITS + QUO_BITS;
  localparam int LIGHT_W = COMPONENT_BITS + 1;

  // chain taps: index 0 is the front end, index k+1 the output of cell k
  logic               ch_valid [QUO_BITS+1];
  logic               ch_ready [QUO_BITS+1];
  logic [NUM_W-1:0]   ch_hue_rem [QUO_BITS+1];
  logic [NUM_W-1:0]   ch_hue_dsh [QUO_BITS+1];
  quo_t               ch_hue_quo [QUO_BITS+1];
  logic [NUM_W-1:0]   ch_sat_rem [QUO_BITS+1];
  logic [NUM_W-1:0]   ch_sat_dsh [QUO_BITS+1];
  quo_t               ch_sat_quo [QUO_BITS+1];
  hue_t               ch_hue_base [QUO_BITS+1];
  logic [LIGHT_W-1:0] ch_light [QUO_BITS+1];

  // front end
  rthc_prep #(
    .CB    (COMPONENT_BITS),
    .NUM_W (NUM_W)
  ) u_prep (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .out_valid    (ch_valid[0]),
    .out_ready    (ch_ready[0]),
    .out_hue_rem  (ch_hue_rem[0]),
    .out_hue_dsh  (ch_hue_dsh[0]),
    .out_sat_rem  (ch_sat_rem[0]),
    .out_sat_dsh  (ch_sat_dsh[0]),
    .out_hue_base (ch_hue_base[0]),
    .out_light    (ch_light[0])
  );

  // quotients start empty
  assign ch_hue_quo[0] = '0;
  assign ch_sat_quo[0] = '0;

  // divider cell chain, MSB of the quotient first
  for (genvar k = 0; k < QUO_BITS; k++) begin : g_cell
    rthc_cell #(
      .NUM_W   (NUM_W),
      .LIGHT_W (LIGHT_W)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .in_valid     (ch_valid[k]),
      .in_ready     (ch_ready[k]),
      .in_hue_rem   (ch_hue_rem[k]),
      .in_hue_dsh   (ch_hue_dsh[k]),
      .in_hue_quo   (ch_hue_quo[k]),
      .in_sat_rem   (ch_sat_rem[k]),
      .in_sat_dsh   (ch_sat_dsh[k]),
      .in_sat_quo   (ch_sat_quo[k]),
      .in_hue_base  (ch_hue_base[k]),
      .in_light     (ch_light[k]),
      .out_valid    (ch_valid[k+1]),
      .out_ready    (ch_ready[k+1]),
      .out_hue_rem  (ch_hue_rem[k+1]),
      .out_hue_dsh  (ch_hue_dsh[k+1]),
      .out_hue_quo  (ch_hue_quo[k+1]),
      .out_sat_rem  (ch_sat_rem[k+1]),
      .out_sat_dsh  (ch_sat_dsh[k+1]),
      .out_sat_quo  (ch_sat_quo[k+1]),
      .out_hue_base (ch_hue_base[k+1]),
      .out_light    (ch_light[k+1])
    );
  end

  // output register: hue = offset + quotient
  logic out_valid_r, out_valid_nxt;
  hue_t hue_nxt;

  assign ch_ready[QUO_BITS] = !out_valid_r || out_ready;
  assign out_valid_nxt      = ch_ready[QUO_BITS] ? ch_valid[QUO_BITS] : out_valid_r;
  assign hue_nxt            = ch_hue_base[QUO_BITS]
                            + hue_t'({{(HUE_W-QUO_BITS){1'b0}}, ch_hue_quo[QUO_BITS]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ch_valid[QUO_BITS] && ch_ready[QUO_BITS]) begin
      out_hue        <= hue_nxt;
      out_saturation <= SAT_W'(ch_sat_quo[QUO_BITS]);
      out_lightness  <= ch_light[QUO_BITS];
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for rgb_to_hsl_converter_core: directed and random pixels
// with random idle and stall on both channels. Depends on rthc_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
  import rthc_pkg::*;

  localparam int COMP_W   = 8;
  localparam int CODE_MAX = (1 << COMP_W) - 1;
  localparam int HUE_SEXT = 3840;

  typedef struct packed {
    hue_t              hue;
    logic [SAT_W-1:0]  sat;
    logic [COMP_W:0]   light;
  } hsl_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [COMP_W-1:0] in_red;
  logic [COMP_W-1:0] in_green;
  logic [COMP_W-1:0] in_blue;
  logic              out_valid;
  logic              out_ready;
  hue_t              out_hue;
  logic [SAT_W-1:0]  out_saturation;
  logic [COMP_W:0]   out_lightness;

  hsl_t pending_hsl[$];
  hsl_t want_hsl;
  int   pixels_sent   = 0;
  int   results_seen  = 0;
  int   mismatch_count = 0;
  bit   hold_steady   = 1'b0;

  rgb_to_hsl_converter_core #(
    .COMPONENT_BITS(COMP_W)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_hue       (out_hue),
    .out_saturation(out_saturation),
    .out_lightness (out_lightness)
  );

  always #4 clk = ~clk;

  // Predicted HSL of one pixel; hue uses floored division
  function automatic hsl_t rgb_to_hsl(input logic [COMP_W-1:0] r, g, b);
    int ri, gi, bi, mx, mn, delta, total, den, num, prod, quo;
    hsl_t res;
    ri = int'(r);
    gi = int'(g);
    bi = int'(b);
    mx = ri;
    mn = ri;
    if (gi > mx) mx = gi;
    if (bi > mx) mx = bi;
    if (gi < mn) mn = gi;
    if (bi < mn) mn = bi;
    delta = mx - mn;
    total = mx + mn;
    res.hue   = '0;
    res.sat   = '0;
    res.light = (COMP_W+1)'(total);
    if (total > 0 && total < 2 * CODE_MAX && delta > 0) begin
      den = (total <= CODE_MAX) ? total : 2 * CODE_MAX - total;
      res.sat = SAT_W'((delta * 4096) / den);
    end
    if (delta > 0) begin
      if (mx == ri && mx != gi) num = gi - bi;
      else if (mx == gi && mx != bi) num = 2 * delta + bi - ri;
      else num = 4 * delta + ri - gi;
      prod = num * HUE_SEXT;
      quo = prod / delta;
      if ((prod % delta) != 0 && prod < 0) quo = quo - 1;
      res.hue = hue_t'(quo);
    end
    return res;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("MISMATCH: %s", msg);
  endtask

  // One input beat; random idle ahead of it unless a steady stretch is on
  task automatic send_pixel(input logic [COMP_W-1:0] r, g, b);
    if (!hold_steady && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 35);
    end
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    do @(posedge clk); while (!in_ready);
    pending_hsl.push_back(rgb_to_hsl(r, g, b));
    pixels_sent++;
  endtask

  // Stop sending and let every outstanding result come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_hsl.size() != 0) @(posedge clk);
  endtask

  // Random pixel biased toward greys, ties, sum at mid scale and rail codes
  task automatic pick_pixel(output logic [COMP_W-1:0] r, g, b);
    logic [COMP_W-1:0] v[3];
    logic [COMP_W-1:0] t;
    int k, j, mx;
    v[0] = COMP_W'($urandom_range(CODE_MAX));
    v[1] = COMP_W'($urandom_range(CODE_MAX));
    v[2] = COMP_W'($urandom_range(CODE_MAX));
    case ($urandom_range(9))
      0: begin
        v[1] = v[0];
        v[2] = v[0];
      end
      1: v[$urandom_range(2)] = v[$urandom_range(2)];
      2: begin
        mx = int'($urandom_range(CODE_MAX, (CODE_MAX + 1) / 2));
        v[0] = COMP_W'(mx);
        v[1] = COMP_W'(CODE_MAX - mx);
        v[2] = COMP_W'($urandom_range(mx, CODE_MAX - mx));
      end
      3: for (k = 0; k < 3; k++) begin
        if ($urandom_range(1)) v[k] = COMP_W'($urandom_range(1) ? CODE_MAX : 0);
      end
      default: ;
    endcase
    for (k = 2; k > 0; k--) begin
      j = $urandom_range(k);
      t = v[k];
      v[k] = v[j];
      v[j] = t;
    end
    r = v[0];
    g = v[1];
    b = v[2];
  endtask

  // Corners: rails, greys, primaries, ties, hue extremes, mid-scale sums
  task automatic test_directed();
    send_pixel(0, 0, 0);
    send_pixel(CODE_MAX, CODE_MAX, CODE_MAX);
    send_pixel(128, 128, 128);
    send_pixel(1, 1, 1);
    send_pixel(CODE_MAX, 0, 0);
    send_pixel(0, CODE_MAX, 0);
    send_pixel(0, 0, CODE_MAX);
    send_pixel(CODE_MAX, CODE_MAX, 0);
    send_pixel(0, CODE_MAX, CODE_MAX);
    send_pixel(CODE_MAX, 0, CODE_MAX);
    send_pixel(CODE_MAX, 0, 1);
    send_pixel(254, 0, CODE_MAX);
    send_pixel(CODE_MAX, CODE_MAX, 254);
    send_pixel(200, 55, 100);
    send_pixel(CODE_MAX, 0, 128);
    send_pixel(1, 0, 0);
    send_pixel(0, 1, 0);
    send_pixel(0, 0, 1);
    send_pixel(CODE_MAX, 254, CODE_MAX);
    send_pixel(254, CODE_MAX, CODE_MAX);
    send_pixel(170, 85, CODE_MAX);
    send_pixel(127, 128, 0);
  endtask

  task automatic test_shaped_random(input int count);
    logic [COMP_W-1:0] r, g, b;
    for (int n = 0; n < count; n++) begin
      pick_pixel(r, g, b);
      send_pixel(r, g, b);
    end
  endtask

  // Back-to-back beats with the receiver always ready
  task automatic test_steady_stream(input int count);
    hold_steady = 1'b1;
    test_shaped_random(count);
    hold_steady = 1'b0;
  endtask

  // Sender pauses mid-stream until the pipeline is empty
  task automatic test_drain_pause();
    test_shaped_random(15);
    wait_drained();
    test_shaped_random(15);
  endtask

  // Receiver: random stalls, none during a steady stretch
  always @(posedge clk) begin
    if (hold_steady) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= 35);
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_hsl.size() == 0) begin
        note_mismatch($sformatf("unexpected beat hue=%0d sat=%0d light=%0d",
                                out_hue, out_saturation, out_lightness));
      end else begin
        want_hsl = pending_hsl.pop_front();
        if (out_hue !== want_hsl.hue || out_saturation !== want_hsl.sat ||
            out_lightness !== want_hsl.light)
          note_mismatch($sformatf(
            "result %0d: exp hue=%0d sat=%0d light=%0d, got hue=%0d sat=%0d light=%0d",
            results_seen, want_hsl.hue, want_hsl.sat, want_hsl.light,
            out_hue, out_saturation, out_lightness));
      end
    end
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("rgb_to_hsl_converter_core test failed");
    $finish;
  end

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_red    <= '0;
    in_green  <= '0;
    in_blue   <= '0;
    out_ready <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_shaped_random(150);
    test_steady_stream(80);
    test_drain_pause();
    test_shaped_random(120);

    wait_drained();
    repeat (24) @(posedge clk);
    if (pending_hsl.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", pending_hsl.size()));

    $display("Covered %0d pixels (corners, biased random, back-to-back, drain pause);",
             pixels_sent);
    $display("%0d results checked, %0d mismatches.", results_seen, mismatch_count);
    if (mismatch_count == 0)
      $display("rgb_to_hsl_converter_core test passed");
    else
      $display("rgb_to_hsl_converter_core test failed");
    $finish;
  end

endmodule
